// ===== src/tpq_pkg.sv =====
// Shared constants for the threshold palette quantizer.
`default_nettype none
package tpq_pkg;

  localparam int PALETTE_SIZE = 1024;
  localparam int IDX_W        = $clog2(PALETTE_SIZE);
  localparam int CNT_W        = IDX_W + 1;
  localparam int COMP_W       = 16;
  localparam int ENTRY_W      = 4 * COMP_W;
  localparam int SQ_W         = 2 * COMP_W;
  localparam int DIST_W       = SQ_W + 2;

  localparam logic [CNT_W-1:0] PALETTE_LIMIT = CNT_W'(PALETTE_SIZE);

  localparam logic [1:0] OP_QUANTIZE = 2'd0;
  localparam logic [1:0] OP_LOOKUP   = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;
  localparam logic [1:0] OP_NOP      = 2'd3;

  localparam logic [2:0] STS_MATCHED  = 3'd0;
  localparam logic [2:0] STS_APPENDED = 3'd1;
  localparam logic [2:0] STS_FULL     = 3'd2;
  localparam logic [2:0] STS_RANGE    = 3'd3;
  localparam logic [2:0] STS_CLEARED  = 3'd4;

endpackage
`default_nettype wire

// ===== src/threshold_palette_quantizer.sv =====
// Threshold palette quantizer: palette memory, scan pipeline and result register.
//
// One item is processed at a time. A quantize reads the palette memory (one
// port, one entry per cycle until a match, registered read) in index order
// through a two-stage distance pipeline. It stops at the first matching entry;
// with no match it scans every used entry and then appends the vector, or
// reports a full palette. A lookup within the count reads the memory; a lookup
// beyond the count, a clear or an unused opcode goes straight to the result.
// The result sits in an output register, so a new item is taken while an
// earlier result waits for transfer. The palette needs no clearing pass after
// reset: entries at or above the count are never read.
`default_nettype none
module threshold_palette_quantizer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [15:0]                     cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_op,
  input  wire logic signed [15:0]              in_comp_x,
  input  wire logic signed [15:0]              in_comp_y,
  input  wire logic signed [15:0]              in_comp_z,
  input  wire logic signed [15:0]              in_comp_w,
  input  wire logic [tpq_pkg::IDX_W-1:0]       in_entry_index,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [tpq_pkg::CNT_W-1:0]            out_result_index,
  output logic [2:0]                           out_status,
  output logic signed [15:0]                   out_x,
  output logic signed [15:0]                   out_y,
  output logic signed [15:0]                   out_z,
  output logic signed [15:0]                   out_w,
  output logic [tpq_pkg::CNT_W-1:0]            out_entry_count
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]                          state_r, state_nxt;
  logic [tpq_pkg::CNT_W-1:0]           count_r, count_nxt;
  logic [15:0]                         radius_r;
  logic [tpq_pkg::SQ_W-1:0]            eps_sq_r;
  logic [tpq_pkg::ENTRY_W-1:0]         vec_r, vec_nxt;
  logic [tpq_pkg::CNT_W-1:0]           iss_r, iss_nxt;
  logic                                s1_v_r, s1_v_nxt;
  logic [tpq_pkg::IDX_W-1:0]           s1_idx_r;
  logic                                s2_v_r, s2_v_nxt;
  logic [tpq_pkg::IDX_W-1:0]           s2_idx_r;
  logic [tpq_pkg::SQ_W-1:0]            sq_r [4];
  logic [tpq_pkg::SQ_W-1:0]            sq_nxt [4];

  logic [tpq_pkg::ENTRY_W-1:0]         mem [tpq_pkg::PALETTE_SIZE];
  logic [tpq_pkg::ENTRY_W-1:0]         rd_data_r;
  logic                                mem_re, mem_we;
  logic [tpq_pkg::IDX_W-1:0]           mem_ra, mem_wa;

  logic [tpq_pkg::CNT_W-1:0]           res_index_r, res_index_nxt;
  logic [2:0]                          res_status_r, res_status_nxt;
  logic [tpq_pkg::ENTRY_W-1:0]         res_entry_r, res_entry_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic [tpq_pkg::CNT_W-1:0]           out_index_r;
  logic [2:0]                          out_status_r;
  logic [tpq_pkg::ENTRY_W-1:0]         out_entry_r;
  logic [tpq_pkg::CNT_W-1:0]           out_count_r;
  logic                                out_load;

  logic                                in_xfer;
  logic                                issue;
  logic                                hit;
  logic                                scan_done;
  logic [tpq_pkg::DIST_W-1:0]          dist_sum;
  logic signed [tpq_pkg::COMP_W:0]     diff [4];
  logic signed [2*tpq_pkg::COMP_W+1:0] prod [4];

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // squared distance stage, fed by the registered memory read
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      diff[k] = $signed({rd_data_r[k*tpq_pkg::COMP_W + tpq_pkg::COMP_W-1],
                         rd_data_r[k*tpq_pkg::COMP_W +: tpq_pkg::COMP_W]})
              - $signed({vec_r[k*tpq_pkg::COMP_W + tpq_pkg::COMP_W-1],
                         vec_r[k*tpq_pkg::COMP_W +: tpq_pkg::COMP_W]});
      prod[k]   = diff[k] * diff[k];
      sq_nxt[k] = prod[k][tpq_pkg::SQ_W-1:0];
    end
  end

  assign dist_sum = tpq_pkg::DIST_W'(sq_r[0]) + tpq_pkg::DIST_W'(sq_r[1])
                  + tpq_pkg::DIST_W'(sq_r[2]) + tpq_pkg::DIST_W'(sq_r[3]);

  assign hit       = (state_r == S_SCAN) && s2_v_r
                  && (dist_sum <= tpq_pkg::DIST_W'(eps_sq_r));
  assign issue     = (state_r == S_SCAN) && (iss_r < count_r) && !hit;
  assign scan_done = (state_r == S_SCAN) && !hit && (iss_r >= count_r)
                  && !s1_v_r && !s2_v_r;
  assign out_load  = (state_r == S_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    vec_nxt        = vec_r;
    iss_nxt        = iss_r;
    s1_v_nxt       = issue;
    s2_v_nxt       = (state_r == S_SCAN) && s1_v_r && !hit;
    res_index_nxt  = res_index_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    mem_re         = 1'b0;
    mem_ra         = iss_r[tpq_pkg::IDX_W-1:0];
    mem_we         = 1'b0;
    mem_wa         = count_r[tpq_pkg::IDX_W-1:0];
    out_valid_nxt  = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_entry_nxt = '0;
          case (in_op)
            tpq_pkg::OP_QUANTIZE: begin
              vec_nxt   = {in_comp_w, in_comp_z, in_comp_y, in_comp_x};
              iss_nxt   = '0;
              state_nxt = S_SCAN;
            end
            tpq_pkg::OP_LOOKUP: begin
              res_index_nxt = tpq_pkg::CNT_W'(in_entry_index);
              if (tpq_pkg::CNT_W'(in_entry_index) < count_r) begin
                mem_re    = 1'b1;
                mem_ra    = in_entry_index;
                state_nxt = S_LOOK;
              end else begin
                res_status_nxt = tpq_pkg::STS_RANGE;
                state_nxt      = S_RESP;
              end
            end
            tpq_pkg::OP_CLEAR: begin
              count_nxt      = '0;
              res_index_nxt  = '0;
              res_status_nxt = tpq_pkg::STS_CLEARED;
              state_nxt      = S_RESP;
            end
            default: begin
              res_index_nxt  = '0;
              res_status_nxt = tpq_pkg::STS_RANGE;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (issue) begin
          mem_re  = 1'b1;
          iss_nxt = iss_r + 1'b1;
        end
        if (hit) begin
          res_index_nxt  = tpq_pkg::CNT_W'(s2_idx_r);
          res_status_nxt = tpq_pkg::STS_MATCHED;
          state_nxt      = S_RESP;
        end else if (scan_done) begin
          if (count_r >= tpq_pkg::PALETTE_LIMIT) begin
            res_index_nxt  = tpq_pkg::PALETTE_LIMIT;
            res_status_nxt = tpq_pkg::STS_FULL;
          end else begin
            mem_we         = 1'b1;
            count_nxt      = count_r + 1'b1;
            res_index_nxt  = count_r;
            res_status_nxt = tpq_pkg::STS_APPENDED;
          end
          state_nxt = S_RESP;
        end
      end
      S_LOOK: begin
        res_entry_nxt  = rd_data_r;
        res_status_nxt = tpq_pkg::STS_MATCHED;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // palette memory with a registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= vec_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      radius_r    <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    eps_sq_r     <= radius_r * radius_r;
    vec_r        <= vec_nxt;
    iss_r        <= iss_nxt;
    s1_idx_r     <= iss_r[tpq_pkg::IDX_W-1:0];
    s2_idx_r     <= s1_idx_r;
    for (int k = 0; k < 4; k++) begin
      sq_r[k] <= sq_nxt[k];
    end
    res_index_r  <= res_index_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    if (out_load) begin
      out_index_r  <= res_index_r;
      out_status_r <= res_status_r;
      out_entry_r  <= res_entry_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_index_r;
  assign out_status       = out_status_r;
  assign out_x            = out_entry_r[15:0];
  assign out_y            = out_entry_r[31:16];
  assign out_z            = out_entry_r[47:32];
  assign out_w            = out_entry_r[63:48];
  assign out_entry_count  = out_count_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tpq_pkg::PALETTE_LIMIT)
    else $error("palette count above capacity");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (count_r < tpq_pkg::PALETTE_LIMIT) && (state_r == S_SCAN))
    else $error("palette write without room");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> count_r == $past(count_r) + 1'b1)
    else $error("append did not bump count");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r || s2_v_r) |-> state_r == S_SCAN)
    else $error("distance pipeline busy outside scan");

  a_append_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == tpq_pkg::STS_APPENDED)
      |-> out_index_r == out_count_r - 1'b1)
    else $error("appended index does not match count");
`endif

endmodule
`default_nettype wire
